FILE: rtl/nfst_pkg.sv
package nfst_pkg;

    // request fields as they stand on the ports
    localparam int MODE_W   = 2;
    localparam int FD_W     = 20;
    localparam int IDX_OUT_W = 10;

    // request modes on the input channel
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FIND   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

    // classified operation carried through the queue
    typedef logic [1:0] t_op;
    localparam t_op OP_INSERT = 2'd0;
    localparam t_op OP_FIND   = 2'd1;
    localparam t_op OP_DELETE = 2'd2;
    localparam t_op OP_NONE   = 2'd3;

    // head of the request queue as seen by the back end
    typedef struct packed {
        logic valid;
        t_op  op;
    } t_q_head;

endpackage

FILE: rtl/nfst_front.sv
module nfst_front #(
    parameter int VALUE_BITS = 20
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [nfst_pkg::MODE_W-1:0] i_mode,
    input  logic [nfst_pkg::FD_W-1:0]   i_fd_value,
    input  logic                     i_clearing,
    input  logic                     i_pop,
    output nfst_pkg::t_q_head        o_head,
    output logic [VALUE_BITS-1:0]    o_q_value
);
    import nfst_pkg::*;

    t_op                   op_cls;
    logic [31:0]           fd_ext;
    logic                  push;
    logic                  pop;

    t_op                   r_q_op  [2];
    logic [VALUE_BITS-1:0] r_q_val [2];
    logic                  r_wp;
    logic                  r_rp;
    logic [1:0]            r_cnt;

    // classify the beat
    always_comb begin
        unique case (i_mode)
            MODE_INSERT: op_cls = OP_INSERT;
            MODE_FIND:   op_cls = OP_FIND;
            MODE_DELETE: op_cls = OP_DELETE;
            default:     op_cls = OP_NONE;
        endcase
    end

    assign fd_ext  = 32'(i_fd_value);
    assign o_ready = !i_clearing && (r_cnt != 2'd2);
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_op[r_wp]  <= op_cls;
            r_q_val[r_wp] <= fd_ext[VALUE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            if (push && !pop)      r_cnt <= r_cnt + 2'd1;
            else if (pop && !push) r_cnt <= r_cnt - 2'd1;
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.op    = r_q_op[r_rp];
    assign o_q_value    = r_q_val[r_rp];

endmodule

FILE: rtl/nfst_back.sv
module nfst_back #(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_BITS  = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  nfst_pkg::t_q_head             i_head,
    input  logic [VALUE_BITS-1:0]         i_q_value,
    output logic                          o_q_pop,
    output logic                          o_clearing,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_hit,
    output logic [nfst_pkg::IDX_OUT_W-1:0] o_slot_index
);
    import nfst_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = IDX_W + 1;
    localparam int ENT_W = VALUE_BITS + 1;
    localparam logic [IDX_W-1:0] LAST_SLOT  = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_DEPTH  = CNT_W'(TABLE_DEPTH);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;

    // entry layout: valid mark on top, value below
    logic [ENT_W-1:0] mem [TABLE_DEPTH];

    logic [1:0]            r_state, n_state;
    logic [IDX_W-1:0]      r_addr, n_addr;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [IDX_W-1:0]      r_ptr, n_ptr;
    t_op                   r_op, n_op;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic                  r_chk_v, n_chk_v;
    logic [IDX_W-1:0]      r_chk_addr, n_chk_addr;
    logic [ENT_W-1:0]      r_rd_data;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_hit, n_out_hit;
    logic [IDX_OUT_W-1:0]  r_out_idx, n_out_idx;

    logic                  issue;
    logic                  rd_en;
    logic                  match;
    logic                  found;
    logic                  exhausted;
    logic                  take;
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [ENT_W-1:0]      wdata;
    logic [IDX_W-1:0]      addr_inc;
    logic [31:0]           idx_ext;

    assign issue    = (r_cnt != CNT_DEPTH);
    assign rd_en    = (r_state == S_SCAN) && issue;
    assign addr_inc = (r_addr == LAST_SLOT) ? '0 : r_addr + IDX_W'(1);
    assign match    = (r_op == OP_INSERT) ? !r_rd_data[VALUE_BITS]
                    : (r_rd_data[VALUE_BITS] && (r_rd_data[VALUE_BITS-1:0] == r_val));
    assign found     = (r_state == S_SCAN) && r_chk_v && match;
    assign exhausted = (r_state == S_SCAN) && r_chk_v && !match && !issue;
    assign take      = (r_state == S_IDLE) && i_head.valid && !r_out_valid;
    assign idx_ext   = 32'(r_chk_addr);

    // single write port: clearing sweep, or the slot an insert or delete settles on
    always_comb begin
        we    = 1'b0;
        waddr = r_chk_addr;
        wdata = {1'b1, r_val};
        if (r_state == S_CLEAR) begin
            we    = 1'b1;
            waddr = r_addr;
            wdata = '0;
        end else if (found && (r_op != OP_FIND)) begin
            we = 1'b1;
            if (r_op == OP_DELETE) wdata = {1'b0, r_rd_data[VALUE_BITS-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        if (rd_en) r_rd_data <= mem[r_addr];
    end

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_cnt       = r_cnt;
        n_ptr       = r_ptr;
        n_op        = r_op;
        n_val       = r_val;
        n_chk_v     = 1'b0;
        n_chk_addr  = r_chk_addr;
        n_out_valid = r_out_valid && !i_ready;
        n_out_hit   = r_out_hit;
        n_out_idx   = r_out_idx;
        unique case (r_state)
            S_CLEAR: begin
                n_addr = addr_inc;
                if (r_addr == LAST_SLOT) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (take) begin
                    n_op  = i_head.op;
                    n_val = i_q_value;
                    n_cnt = '0;
                    n_addr = (i_head.op == OP_INSERT) ? r_ptr : '0;
                    if (i_head.op == OP_NONE) begin
                        n_out_valid = 1'b1;
                        n_out_hit   = 1'b0;
                        n_out_idx   = '0;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (issue) begin
                    n_chk_v    = 1'b1;
                    n_chk_addr = r_addr;
                    n_addr     = addr_inc;
                    n_cnt      = r_cnt + CNT_W'(1);
                end
                if (found) begin
                    n_state     = S_IDLE;
                    n_chk_v     = 1'b0;
                    n_out_valid = 1'b1;
                    n_out_hit   = 1'b1;
                    n_out_idx   = idx_ext[IDX_OUT_W-1:0];
                    if (r_op == OP_INSERT) n_ptr = r_chk_addr;
                end else if (exhausted) begin
                    n_state     = S_IDLE;
                    n_chk_v     = 1'b0;
                    n_out_valid = 1'b1;
                    n_out_hit   = 1'b0;
                    n_out_idx   = '0;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_cnt       <= '0;
            r_ptr       <= '0;
            r_chk_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_cnt       <= n_cnt;
            r_ptr       <= n_ptr;
            r_chk_v     <= n_chk_v;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_val      <= n_val;
        r_chk_addr <= n_chk_addr;
        r_out_hit  <= n_out_hit;
        r_out_idx  <= n_out_idx;
    end

    assign o_q_pop      = take;
    assign o_clearing   = (r_state == S_CLEAR);
    assign o_valid      = r_out_valid;
    assign o_hit        = r_out_hit;
    assign o_slot_index = r_out_idx;

endmodule

FILE: rtl/next_fit_slot_table_top.sv
// next-fit slot table: TABLE_DEPTH slots of VALUE_BITS-bit descriptor values, each with a
// valid mark, held in one single-port-write, single-port-read memory. insert puts the value
// in the first free slot found by a circular walk that starts at the slot of the last insert
// (that slot itself included) and moves the pointer there; find returns the lowest valid slot
// holding the value; delete frees that same slot. a miss, a full table or mode 3 returns hit
// 0 with slot 0. every insert, find or delete is a linear walk of the memory at one slot
// per clock through the registered read port; mode 3 returns its result without a walk.
// after reset a clearing sweep writes every slot free, during which o_ready stays low. a
// two-beat request queue sits in front of the walk engine and the result leaves through an
// output register, so requests are taken while a walk runs or a result waits
module next_fit_slot_table_top #(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_BITS  = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [nfst_pkg::MODE_W-1:0]   i_mode,
    input  logic [nfst_pkg::FD_W-1:0]     i_fd_value,
    // result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_hit,
    output logic [nfst_pkg::IDX_OUT_W-1:0] o_slot_index
);
    import nfst_pkg::*;

    t_q_head               head;
    logic [VALUE_BITS-1:0] q_value;
    logic                  q_pop;
    logic                  clearing;

    // front: decode the mode, trim the value, buffer the beat
    nfst_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_mode     (i_mode),
        .i_fd_value (i_fd_value),
        .i_clearing (clearing),
        .i_pop      (q_pop),
        .o_head     (head),
        .o_q_value  (q_value)
    );

    // back: table memory, walk engine, insert pointer and result register
    nfst_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_BITS  (VALUE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_q_value    (q_value),
        .o_q_pop      (q_pop),
        .o_clearing   (clearing),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_hit        (o_hit),
        .o_slot_index (o_slot_index)
    );

endmodule
